[sv/assert_macros.svh]
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A check that is clocked on clk and switched off while rst is high.
`define CHECK_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// The same check with a fixed message.
`define CHECK_CLK_PLAIN(lbl, prop) \
  `CHECK_CLK(lbl, prop, "check failed")

`endif

[sv/blfs_pkg.sv]
package blfs_pkg;

  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 32;

  localparam logic [CfgIndexW-1:0] REG_SYNC_FIRST  = 3'd0;
  localparam logic [CfgIndexW-1:0] REG_SYNC_SECOND = 3'd1;
  localparam logic [CfgIndexW-1:0] REG_SYNC_THIRD  = 3'd2;
  localparam logic [CfgIndexW-1:0] REG_HEADER      = 3'd3;
  localparam logic [CfgIndexW-1:0] REG_POLY        = 3'd4;

  localparam logic [7:0]  SYNC_FIRST_RST  = 8'hAA;
  localparam logic [7:0]  SYNC_SECOND_RST = 8'h44;
  localparam logic [7:0]  SYNC_THIRD_RST  = 8'h12;
  localparam logic [7:0]  HEADER_RST      = 8'd28;
  localparam logic [7:0]  HEADER_MIN      = 8'd20;
  localparam logic [31:0] POLY_RST        = 32'hEDB88320;

  localparam int unsigned PosW = 17;

  localparam logic [2:0] PH_HUNT  = 3'd0;
  localparam logic [2:0] PH_SYNC1 = 3'd1;
  localparam logic [2:0] PH_SYNC2 = 3'd2;
  localparam logic [2:0] PH_DATA  = 3'd3;
  localparam logic [2:0] PH_CRC   = 3'd4;

  typedef struct packed {
    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
    logic [7:0]  sync_third;
    logic [7:0]  header_bytes;
    logic [31:0] poly;
  } cfg_t;

  typedef struct packed {
    logic [15:0] message_id;
    logic [1:0]  message_format;
    logic [15:0] body_length;
    logic [15:0] week_number;
    logic [31:0] week_milliseconds;
    logic        crc_ok;
  } frame_rec_t;

  // One byte of a reflected CRC, eight bit steps unrolled.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b,
                                           input logic [31:0] poly);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[sv/blfs_cfg.sv]
module blfs_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [blfs_pkg::CfgIndexW-1:0]   cfg_index,
  input  logic [blfs_pkg::CfgDataW-1:0]    cfg_data,
  output blfs_pkg::cfg_t                   cfg
);
  import blfs_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_first   <= SYNC_FIRST_RST;
      cfg.sync_second  <= SYNC_SECOND_RST;
      cfg.sync_third   <= SYNC_THIRD_RST;
      cfg.header_bytes <= HEADER_RST;
      cfg.poly         <= POLY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SYNC_FIRST:  cfg.sync_first   <= cfg_data[7:0];
        REG_SYNC_SECOND: cfg.sync_second  <= cfg_data[7:0];
        REG_SYNC_THIRD:  cfg.sync_third   <= cfg_data[7:0];
        REG_HEADER:      cfg.header_bytes <= cfg_data[7:0];
        REG_POLY:        cfg.poly         <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

[sv/blfs_framer.sv]
module blfs_framer (
  input  logic                 clk,
  input  logic                 rst,
  input  blfs_pkg::cfg_t       cfg,
  input  logic                 accept,
  input  logic [7:0]           data_byte,
  output logic                 emit_due,
  output blfs_pkg::frame_rec_t rec
);
  import blfs_pkg::*;

  logic [2:0]      phase, phase_next;
  logic [PosW-1:0] byte_position, byte_position_next;
  logic [31:0]     running_crc, running_crc_next;
  logic [31:0]     received_crc, received_crc_next;
  logic [15:0]     cap_id, cap_id_next;
  logic [1:0]      cap_fmt, cap_fmt_next;
  logic [15:0]     cap_len, cap_len_next;
  logic [15:0]     cap_week, cap_week_next;
  logic [31:0]     cap_ms, cap_ms_next;

  logic [7:0]      hdr;
  logic [PosW-1:0] data_end, data_end_next, pos_inc, crc_offset;
  logic [1:0]      k;
  logic [31:0]     crc_cont, crc_start;

  assign hdr        = (cfg.header_bytes < HEADER_MIN) ? HEADER_MIN : cfg.header_bytes;
  assign data_end   = {9'd0, hdr} + {1'b0, cap_len};
  assign data_end_next = {9'd0, hdr} + {1'b0, cap_len_next};
  assign pos_inc    = byte_position + PosW'(1);
  assign crc_offset = byte_position - data_end;
  assign k          = crc_offset[1:0];
  assign crc_cont   = crc_byte(running_crc, data_byte, cfg.poly);
  assign crc_start  = crc_byte(32'd0, data_byte, cfg.poly);
  assign emit_due   = (phase == PH_CRC) && (k == 2'd3);

  always_comb begin
    phase_next         = phase;
    byte_position_next = byte_position;
    running_crc_next   = running_crc;
    received_crc_next  = received_crc;
    cap_id_next        = cap_id;
    cap_fmt_next       = cap_fmt;
    cap_len_next       = cap_len;
    cap_week_next      = cap_week;
    cap_ms_next        = cap_ms;

    unique case (phase)
      PH_SYNC1: begin
        if (data_byte == cfg.sync_second) begin
          phase_next       = PH_SYNC2;
          running_crc_next = crc_cont;
        end else if (data_byte == cfg.sync_first) begin
          phase_next       = PH_SYNC1;
          running_crc_next = crc_start;
        end else begin
          phase_next = PH_HUNT;
        end
      end
      PH_SYNC2: begin
        if (data_byte == cfg.sync_third) begin
          phase_next         = PH_DATA;
          running_crc_next   = crc_cont;
          byte_position_next = PosW'(3);
          received_crc_next  = 32'd0;
        end else if (data_byte == cfg.sync_first) begin
          phase_next       = PH_SYNC1;
          running_crc_next = crc_start;
        end else begin
          phase_next = PH_HUNT;
        end
      end
      PH_DATA: begin
        running_crc_next = crc_cont;
        case (byte_position)
          PosW'(4):  cap_id_next[7:0]    = data_byte;
          PosW'(5):  cap_id_next[15:8]   = data_byte;
          PosW'(6):  cap_fmt_next        = data_byte[5:4];
          PosW'(8):  cap_len_next[7:0]   = data_byte;
          PosW'(9):  cap_len_next[15:8]  = data_byte;
          PosW'(14): cap_week_next[7:0]  = data_byte;
          PosW'(15): cap_week_next[15:8] = data_byte;
          PosW'(16): cap_ms_next[7:0]    = data_byte;
          PosW'(17): cap_ms_next[15:8]   = data_byte;
          PosW'(18): cap_ms_next[23:16]  = data_byte;
          PosW'(19): cap_ms_next[31:24]  = data_byte;
          default: ;
        endcase
        byte_position_next = pos_inc;
        if (pos_inc >= data_end_next) begin
          phase_next = PH_CRC;
        end
      end
      PH_CRC: begin
        case (k)
          2'd0:    received_crc_next = received_crc | {24'd0, data_byte};
          2'd1:    received_crc_next = received_crc | {16'd0, data_byte, 8'd0};
          2'd2:    received_crc_next = received_crc | {8'd0, data_byte, 16'd0};
          default: received_crc_next = received_crc | {data_byte, 24'd0};
        endcase
        byte_position_next = pos_inc;
        if (k == 2'd3) begin
          phase_next         = PH_HUNT;
          byte_position_next = '0;
          running_crc_next   = 32'd0;
        end
      end
      default: begin
        if (data_byte == cfg.sync_first) begin
          phase_next       = PH_SYNC1;
          running_crc_next = crc_start;
        end else begin
          phase_next = PH_HUNT;
        end
      end
    endcase
  end

  assign rec.message_id        = cap_id;
  assign rec.message_format    = cap_fmt;
  assign rec.body_length       = cap_len;
  assign rec.week_number       = cap_week;
  assign rec.week_milliseconds = cap_ms;
  assign rec.crc_ok            = (running_crc == received_crc_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      byte_position <= '0;
      running_crc   <= 32'd0;
      received_crc  <= 32'd0;
      cap_id        <= 16'd0;
      cap_fmt       <= 2'd0;
      cap_len       <= 16'd0;
      cap_week      <= 16'd0;
      cap_ms        <= 32'd0;
    end else if (accept) begin
      phase         <= phase_next;
      byte_position <= byte_position_next;
      running_crc   <= running_crc_next;
      received_crc  <= received_crc_next;
      cap_id        <= cap_id_next;
      cap_fmt       <= cap_fmt_next;
      cap_len       <= cap_len_next;
      cap_week      <= cap_week_next;
      cap_ms        <= cap_ms_next;
    end
  end

`include "assert_macros.svh"

  `CHECK_CLK(frame_end_rearms,
             (accept && emit_due) |=>
               (phase == PH_HUNT && byte_position == '0 && running_crc == 32'd0),
             "frame end did not return to hunting")
  `CHECK_CLK(sync_done_starts_data,
             (accept && phase == PH_SYNC2 && data_byte == cfg.sync_third) |=>
               (phase == PH_DATA && byte_position == PosW'(3) && received_crc == 32'd0),
             "third sync byte did not open a frame")
  `CHECK_CLK_PLAIN(data_advances,
                   (accept && phase == PH_DATA) |=>
                     (byte_position == $past(byte_position) + PosW'(1)))

endmodule

[sv/blfs_outreg.sv]
module blfs_outreg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  blfs_pkg::frame_rec_t rec_in,
  input  logic                 out_ready,
  output logic                 out_valid,
  output blfs_pkg::frame_rec_t rec_out
);
  import blfs_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rec_out <= rec_in;
    end
  end

endmodule

[sv/binary_log_frame_sync_crc32.sv]
// Binary log frame synchroniser with reflected CRC-32 check.
// The input channel (in_valid, in_ready, data_byte) takes one stream byte per
// request. The block hunts for three sync bytes, captures the header fields and
// runs the CRC over header and body, one accepted byte per cycle through an
// unrolled eight-step CRC update. On the last of the four trailing CRC bytes it
// produces one frame record on the output channel (out_valid, out_ready and
// the field ports), with crc_ok set when the CRCs agree.
// Throughput is one byte per cycle unless a frame end is stalled. The record
// appears the cycle after the last CRC byte is taken, in one output register.
// If the receiver stalls, bytes that complete no frame are still taken; only
// a byte that would finish a frame waits until the held record is taken.
// The configuration port (cfg_we, cfg_index, cfg_data) writes the register
// that cfg_index names; indexes beyond the list are ignored.
// Synchronous reset restores the default sync bytes 0xAA 0x44 0x12, a header
// of 28 bytes and polynomial 0xEDB88320, returns to hunting and drops any
// held record.
module binary_log_frame_sync_crc32 (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [blfs_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [blfs_pkg::CfgDataW-1:0]  cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     data_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [15:0]                    message_id,
  output logic [1:0]                     message_format,
  output logic [15:0]                    body_length,
  output logic [15:0]                    week_number,
  output logic [31:0]                    week_milliseconds,
  output logic                           crc_ok
);
  import blfs_pkg::*;

  cfg_t       cfg;
  frame_rec_t rec_live, rec_held;
  logic       emit_due, accept, res_emit;

  assign in_ready = !emit_due || !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign res_emit = accept && emit_due;

  blfs_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  blfs_framer u_framer (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .accept    (accept),
    .data_byte (data_byte),
    .emit_due  (emit_due),
    .rec       (rec_live)
  );

  blfs_outreg u_outreg (
    .clk       (clk),
    .rst       (rst),
    .load      (res_emit),
    .rec_in    (rec_live),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .rec_out   (rec_held)
  );

  assign message_id        = rec_held.message_id;
  assign message_format    = rec_held.message_format;
  assign body_length       = rec_held.body_length;
  assign week_number       = rec_held.week_number;
  assign week_milliseconds = rec_held.week_milliseconds;
  assign crc_ok            = rec_held.crc_ok;

`include "assert_macros.svh"

  `CHECK_CLK(no_record_overwrite, res_emit |-> (!out_valid || out_ready), "record issued over a held one")
  `CHECK_CLK(record_has_source, $rose(out_valid) |-> $past(res_emit), "record appeared without a frame end")
  `CHECK_CLK_PLAIN(stall_only_on_frame_end, !in_ready |-> (out_valid && !out_ready && emit_due))

endmodule
